// ----- rtl/core/nnta_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnta_pkg
// Shared types and constants of the nearest neighbor track association block.
// ----------------------------------------------------------------------------
package nnta_pkg;

  localparam int unsigned FRAMES_DEF = 4;
  localparam int unsigned OBJECTS_DEF = 16;

  localparam int unsigned POS_W = 12;
  localparam int unsigned FRAME_W = 24;
  localparam int unsigned ID_W = 16;
  localparam int unsigned SPEED_W = 32;
  localparam int unsigned DIST_W = 13;
  localparam int unsigned SQ_W = 26;
  localparam int unsigned NUM_W = 37;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FPS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MPP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 3'd4;

  localparam logic [12:0] MATCH_LIMIT_RST = 13'd50;
  localparam logic [7:0] FPS_RST = 8'd30;
  localparam logic [15:0] MPP_RST = 16'd655;
  localparam logic [7:0] PERIOD_RST = 8'd5;
  localparam logic [16:0] GAIN_RST = 17'd32768;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [FRAME_W-1:0] frame;
    logic [ID_W-1:0] id;
    logic [SPEED_W-1:0] speed;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_LOAD,
    ST_CMP,
    ST_SQRT,
    ST_SQFIN,
    ST_DECIDE,
    ST_MOD,
    ST_MUL1,
    ST_MUL2,
    ST_ZSTART,
    ST_ZDIV,
    ST_BLEND,
    ST_BLEND2,
    ST_WRITE
  } state_e;

endpackage

// ----- rtl/core/nnta_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnta_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nnta_div #(
  parameter int unsigned NW = 37,
  parameter int unsigned DW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quotient_o,
  output logic [DW-1:0] remainder_o
);

  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem_q;
  logic [NW-1:0]    quo_q;
  logic [DW-1:0]    dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [DW:0]      shifted;
  logic             take;

  assign shifted = {rem_q, quo_q[NW-1]};
  assign take = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(NW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        done_q <= (cnt_q == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      // The partial remainder stays below the divisor, so DW bits hold it.
      rem_q <= take ? DW'(shifted - {1'b0, dvs_q}) : shifted[DW-1:0];
      quo_q <= {quo_q[NW-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quotient_o = quo_q;
  assign remainder_o = rem_q;

endmodule

// ----- rtl/core/nearest_neighbor_track_assoc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_track_assoc
// Nearest neighbor centroid tracker with a frame history in one memory.
// ----------------------------------------------------------------------------
// Detections enter on the input channel (in_valid_i / in_stall_o), one result
// per detection leaves on the output channel (out_valid_o / out_stall_i). An
// empty frame marker gives no result. Registers are written through the
// cfg port, which is always ready; write them only while the block is idle.
// The history holds FRAMES+1 frame slots; the slot after the newest one is
// where the current frame is staged, so committing a frame is only a pointer
// and count update. Each stored entry is read from the memory once, and an
// entry that improves the best distance adds a 13 step square root. A match
// then runs the divider for the period check and, when the frame number is
// a multiple of the period, once more for the speed. The next request is
// taken while the previous result still waits in the output register; a
// result that cannot be handed over because the receiver stalls holds the
// next one back. Reset clears all control state; the history memory needs
// no clearing.
// ----------------------------------------------------------------------------
module nearest_neighbor_track_assoc #(
  parameter int unsigned FRAMES = nnta_pkg::FRAMES_DEF,
  parameter int unsigned OBJECTS_PER_FRAME = nnta_pkg::OBJECTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_kind_i,
  input  logic [11:0] in_pos_x_i,
  input  logic [11:0] in_pos_y_i,
  input  logic [23:0] in_frame_number_i,
  input  logic        in_last_in_frame_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_track_id_o,
  output logic [31:0] out_speed_o,
  output logic        out_is_new_track_o,
  output logic        out_not_stored_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  localparam int unsigned SLOTS = FRAMES + 1;
  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned IW = (OBJECTS_PER_FRAME > 1) ? $clog2(OBJECTS_PER_FRAME) : 1;
  localparam int unsigned CW = $clog2(OBJECTS_PER_FRAME + 1);
  localparam int unsigned HW = $clog2(FRAMES + 1);
  localparam int unsigned DEPTH = SLOTS << IW;

  nnta_pkg::state_e state_q, state_d;

  logic [12:0] match_limit_q;
  logic [7:0]  fps_q;
  logic [15:0] mpp_q;
  logic [7:0]  period_q;
  logic [16:0] gain_q;

  nnta_pkg::entry_t hist_mem [DEPTH];
  nnta_pkg::entry_t rd_q;
  nnta_pkg::entry_t cand_q;
  nnta_pkg::entry_t wr_entry;

  logic [CW-1:0] frame_cnt_q [SLOTS];
  logic [SW-1:0] newest_slot_q;
  logic [HW-1:0] frames_held_q;
  logic [CW-1:0] staged_q;
  logic [15:0]   next_id_q;

  logic [11:0] px_q, py_q;
  logic [23:0] fn_q;
  logic        last_q;

  logic [SW-1:0] slot_q;
  logic [HW-1:0] k_q;
  logic [CW-1:0] idx_q;
  logic          found_q;
  logic [12:0]   best_d_q;
  logic [25:0]   best_sq_q;
  logic [24:0]   sq_q;
  logic [25:0]   sv_q, sr_q, sbit_q;

  logic [20:0] prod1_q;
  logic [36:0] prod2_q;
  logic [31:0] zs_q;
  logic [48:0] bprod_q;
  logic [31:0] speed_q;
  logic [15:0] cur_id_q;
  logic        is_new_q;

  logic        out_valid_q;
  logic [15:0] out_id_q;
  logic [31:0] out_speed_q;
  logic        out_new_q;
  logic        out_ns_q;

  logic in_accept, out_free, entry_left, sq_take, match, staged_room;
  logic mem_re, mem_we, div_start, push_en;
  logic [CW-1:0] push_cnt;
  logic [SW-1:0] stage_slot, prev_slot;
  logic [SW+IW-1:0] raddr, waddr;
  logic [11:0] dx, dy;
  logic [25:0] sqrt_sum;

  logic [36:0] div_dividend, div_quo;
  logic [23:0] div_divisor, div_rem, fd;
  logic        div_done;

  logic [31:0] diff;
  logic [32:0] up_sum;
  logic [32:0] corr;

  assign cfg_ready_o = 1'b1;
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign stage_slot = (newest_slot_q == SW'(FRAMES)) ? '0 : newest_slot_q + 1'b1;
  assign prev_slot = (slot_q == '0) ? SW'(FRAMES) : slot_q - 1'b1;
  assign entry_left = idx_q < frame_cnt_q[slot_q];
  assign raddr = {slot_q, idx_q[IW-1:0]};
  assign waddr = {stage_slot, staged_q[IW-1:0]};
  assign staged_room = staged_q < CW'(OBJECTS_PER_FRAME);

  assign dx = (rd_q.x > px_q) ? rd_q.x - px_q : px_q - rd_q.x;
  assign dy = (rd_q.y > py_q) ? rd_q.y - py_q : py_q - rd_q.y;
  // floor(sqrt(s)) < best exactly when s < best*best.
  assign sq_take = !found_q || ({1'b0, sq_q} < best_sq_q);
  assign sqrt_sum = sr_q + sbit_q;
  assign match = found_q && (best_d_q < match_limit_q);

  assign fd = (fn_q - cand_q.frame == '0) ? 24'd1 : fn_q - cand_q.frame;
  assign diff = (zs_q >= cand_q.speed) ? zs_q - cand_q.speed : cand_q.speed - zs_q;
  assign corr = bprod_q[48:16];
  assign up_sum = {1'b0, cand_q.speed} + corr;

  assign wr_entry = '{x: px_q, y: py_q, frame: fn_q, id: cur_id_q, speed: speed_q};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nnta_pkg::ST_IDLE: begin
        if (in_accept && !in_kind_i) state_d = nnta_pkg::ST_FIND;
      end
      nnta_pkg::ST_FIND: begin
        if (k_q == frames_held_q) state_d = nnta_pkg::ST_DECIDE;
        else if (entry_left) state_d = nnta_pkg::ST_LOAD;
      end
      nnta_pkg::ST_LOAD: state_d = nnta_pkg::ST_CMP;
      nnta_pkg::ST_CMP: state_d = sq_take ? nnta_pkg::ST_SQRT : nnta_pkg::ST_FIND;
      nnta_pkg::ST_SQRT: begin
        if (sbit_q[0]) state_d = nnta_pkg::ST_SQFIN;
      end
      nnta_pkg::ST_SQFIN: state_d = nnta_pkg::ST_FIND;
      nnta_pkg::ST_DECIDE: state_d = match ? nnta_pkg::ST_MOD : nnta_pkg::ST_WRITE;
      nnta_pkg::ST_MOD: begin
        if (div_done) state_d = (div_rem == '0) ? nnta_pkg::ST_MUL1 : nnta_pkg::ST_WRITE;
      end
      nnta_pkg::ST_MUL1: state_d = nnta_pkg::ST_MUL2;
      nnta_pkg::ST_MUL2: state_d = nnta_pkg::ST_ZSTART;
      nnta_pkg::ST_ZSTART: state_d = nnta_pkg::ST_ZDIV;
      nnta_pkg::ST_ZDIV: begin
        if (div_done) state_d = nnta_pkg::ST_BLEND;
      end
      nnta_pkg::ST_BLEND: begin
        state_d = (cand_q.speed == '0) ? nnta_pkg::ST_WRITE : nnta_pkg::ST_BLEND2;
      end
      nnta_pkg::ST_BLEND2: state_d = nnta_pkg::ST_WRITE;
      nnta_pkg::ST_WRITE: begin
        if (out_free) state_d = nnta_pkg::ST_IDLE;
      end
      default: state_d = nnta_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall_o = (state_q != nnta_pkg::ST_IDLE);
    mem_re = (state_q == nnta_pkg::ST_FIND) && (k_q != frames_held_q) && entry_left;
    mem_we = (state_q == nnta_pkg::ST_WRITE) && out_free && staged_room;
    div_start = (state_q == nnta_pkg::ST_DECIDE && match) ||
                (state_q == nnta_pkg::ST_ZSTART);
    push_en = 1'b0;
    push_cnt = '0;
    if (state_q == nnta_pkg::ST_IDLE && in_accept && in_kind_i) begin
      push_en = 1'b1;
    end else if (state_q == nnta_pkg::ST_WRITE && out_free && last_q) begin
      push_en = 1'b1;
      push_cnt = staged_room ? staged_q + 1'b1 : staged_q;
    end
    if (state_q == nnta_pkg::ST_DECIDE) begin
      div_dividend = 37'(fn_q);
      div_divisor = (period_q == '0) ? 24'd1 : 24'(period_q);
    end else begin
      div_dividend = prod2_q;
      div_divisor = fd;
    end
  end

  nnta_div #(
    .NW(nnta_pkg::NUM_W),
    .DW(nnta_pkg::FRAME_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  // History memory: the staging slot is never one that the scan reads, so
  // reads and writes never touch the same entry.
  always_ff @(posedge clk_i) begin
    if (mem_we) hist_mem[waddr] <= wr_entry;
    if (mem_re) rd_q <= hist_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nnta_pkg::ST_IDLE;
      match_limit_q <= nnta_pkg::MATCH_LIMIT_RST;
      fps_q <= nnta_pkg::FPS_RST;
      mpp_q <= nnta_pkg::MPP_RST;
      period_q <= nnta_pkg::PERIOD_RST;
      gain_q <= nnta_pkg::GAIN_RST;
      for (int s = 0; s < SLOTS; s++) frame_cnt_q[s] <= '0;
      newest_slot_q <= '0;
      frames_held_q <= '0;
      staged_q <= '0;
      next_id_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          nnta_pkg::CFG_MATCH_LIMIT: match_limit_q <= cfg_data_i[12:0];
          nnta_pkg::CFG_FPS: fps_q <= cfg_data_i[7:0];
          nnta_pkg::CFG_MPP: mpp_q <= cfg_data_i[15:0];
          nnta_pkg::CFG_PERIOD: period_q <= cfg_data_i[7:0];
          nnta_pkg::CFG_GAIN: gain_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == nnta_pkg::ST_WRITE && out_free) begin
        out_valid_q <= 1'b1;
        if (is_new_q) next_id_q <= next_id_q + 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (push_en) begin
        frame_cnt_q[stage_slot] <= push_cnt;
        newest_slot_q <= stage_slot;
        staged_q <= '0;
        if (frames_held_q < HW'(FRAMES)) frames_held_q <= frames_held_q + 1'b1;
      end else if (state_q == nnta_pkg::ST_WRITE && out_free && staged_room) begin
        staged_q <= staged_q + 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      nnta_pkg::ST_IDLE: begin
        px_q <= in_pos_x_i;
        py_q <= in_pos_y_i;
        fn_q <= in_frame_number_i;
        last_q <= in_last_in_frame_i;
        slot_q <= newest_slot_q;
        k_q <= '0;
        idx_q <= '0;
        found_q <= 1'b0;
      end
      nnta_pkg::ST_FIND: begin
        if (k_q != frames_held_q && !entry_left) begin
          k_q <= k_q + 1'b1;
          slot_q <= prev_slot;
          idx_q <= '0;
        end
      end
      nnta_pkg::ST_LOAD: begin
        sq_q <= {13'd0, dx} * {13'd0, dx} + {13'd0, dy} * {13'd0, dy};
      end
      nnta_pkg::ST_CMP: begin
        sv_q <= 26'(sq_q);
        sr_q <= '0;
        sbit_q <= 26'd1 << 24;
        if (!sq_take) idx_q <= idx_q + 1'b1;
      end
      nnta_pkg::ST_SQRT: begin
        if (sv_q >= sqrt_sum) begin
          sv_q <= sv_q - sqrt_sum;
          sr_q <= (sr_q >> 1) + sbit_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      nnta_pkg::ST_SQFIN: begin
        best_d_q <= sr_q[12:0];
        best_sq_q <= {13'd0, sr_q[12:0]} * {13'd0, sr_q[12:0]};
        cand_q <= rd_q;
        found_q <= 1'b1;
        idx_q <= idx_q + 1'b1;
      end
      nnta_pkg::ST_DECIDE: begin
        if (match) begin
          cur_id_q <= cand_q.id;
          is_new_q <= 1'b0;
        end else begin
          cur_id_q <= next_id_q;
          is_new_q <= 1'b1;
          speed_q <= '0;
        end
      end
      nnta_pkg::ST_MOD: begin
        if (div_done) speed_q <= cand_q.speed;
      end
      nnta_pkg::ST_MUL1: prod1_q <= {8'd0, best_d_q} * {13'd0, fps_q};
      nnta_pkg::ST_MUL2: prod2_q <= {16'd0, prod1_q} * {21'd0, mpp_q};
      nnta_pkg::ST_ZDIV: begin
        if (div_done) zs_q <= (div_quo[36:32] != '0) ? '1 : div_quo[31:0];
      end
      nnta_pkg::ST_BLEND: begin
        speed_q <= zs_q;
        bprod_q <= {32'd0, gain_q} * {17'd0, diff};
      end
      nnta_pkg::ST_BLEND2: begin
        if (zs_q >= cand_q.speed) begin
          speed_q <= up_sum[32] ? '1 : up_sum[31:0];
        end else begin
          speed_q <= (corr >= {1'b0, cand_q.speed}) ? '0 : cand_q.speed - corr[31:0];
        end
      end
      nnta_pkg::ST_WRITE: begin
        if (out_free) begin
          out_id_q <= cur_id_q;
          out_speed_q <= speed_q;
          out_new_q <= is_new_q;
          out_ns_q <= !staged_room;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_track_id_o = out_id_q;
  assign out_speed_o = out_speed_q;
  assign out_is_new_track_o = out_new_q;
  assign out_not_stored_o = out_ns_q;

  a_stage_not_newest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (stage_slot != newest_slot_q))
    else $error("staging write hits the newest committed frame");

  a_staged_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    staged_q <= CW'(OBJECTS_PER_FRAME))
    else $error("staged count exceeds frame capacity");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == nnta_pkg::ST_MOD || state_q == nnta_pkg::ST_ZDIV))
    else $error("divider finished with no waiting state");

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_en |=> (frames_held_q != '0))
    else $error("frame push did not count a held frame");

endmodule
